[rtl/core/pae_pkg.sv]
// Shared constants, codes and types for the positional array engine.
`timescale 1ns / 1ps

package pae_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int DATA_W = 32;

	// command codes
	localparam logic [2:0] FN_CLEAR  = 3'd0;
	localparam logic [2:0] FN_INSERT = 3'd1;
	localparam logic [2:0] FN_DELETE = 3'd2;
	localparam logic [2:0] FN_ASC    = 3'd3;
	localparam logic [2:0] FN_DESC   = 3'd4;
	localparam logic [2:0] FN_FIND   = 3'd5;
	localparam logic [2:0] FN_DUMP   = 3'd6;

	// result status codes
	localparam logic [1:0] RS_DONE   = 2'd0;
	localparam logic [1:0] RS_REJECT = 2'd1;
	localparam logic [1:0] RS_EMPTY  = 2'd2;

	// per-cell operations
	localparam logic [2:0] CELL_HOLD   = 3'd0;
	localparam logic [2:0] CELL_INSERT = 3'd1;
	localparam logic [2:0] CELL_DELETE = 3'd2;
	localparam logic [2:0] CELL_SORT   = 3'd3;
	localparam logic [2:0] CELL_ROTATE = 3'd4;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [CNT_W-1:0] pos;
		word_t            value;
		logic [CNT_W-1:0] count;
		logic             phase;
		logic             desc;
	} cell_ctl_t;

endpackage

[rtl/core/pae_cell.sv]
// One list cell: holds one entry and trades it with its neighbours.
`timescale 1ns / 1ps

module pae_cell
	import pae_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  word_t            left_data,
	input  word_t            right_data,
	output word_t            data
);

	word_t            data_q;
	word_t            data_nx;
	logic [CNT_W-1:0] idx_w;
	logic [CNT_W-1:0] idx_up;
	logic             pair_lo;
	logic             pair_hi;
	logic             swap_lo;
	logic             swap_hi;

	assign idx_w  = CNT_W'(idx);
	assign idx_up = idx_w + CNT_W'(1);

	// odd-even transposition: low side pairs with right, high side with left
	assign pair_lo = (idx[0] == ctl.phase) && (idx_up < ctl.count);
	assign pair_hi = (idx[0] != ctl.phase) && (idx_w != '0) && (idx_w < ctl.count);
	assign swap_lo = ctl.desc ? (data_q < right_data) : (right_data < data_q);
	assign swap_hi = ctl.desc ? (left_data < data_q) : (data_q < left_data);

	always_comb begin
		data_nx = data_q;
		unique case (ctl.op)
			CELL_HOLD: data_nx = data_q;
			CELL_INSERT: begin
				if (idx_w > ctl.pos)
					data_nx = left_data;
				else if (idx_w == ctl.pos)
					data_nx = ctl.value;
			end
			CELL_DELETE: begin
				if (idx_w >= ctl.pos)
					data_nx = right_data;
			end
			CELL_SORT: begin
				if (pair_lo && swap_lo)
					data_nx = right_data;
				else if (pair_hi && swap_hi)
					data_nx = left_data;
			end
			CELL_ROTATE: data_nx = right_data;
			default: data_nx = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nx;
	end

	assign data = data_q;

endmodule

[rtl/core/positional_array_engine.sv]
// Latency: clear, insert, delete and rejected commands answer one cycle after acceptance.
// Sorts take DEPTH odd-even rounds in the cell chain, find and dump DEPTH ring rotations
// (dump longer if the result side stalls), plus one cycle to post a single result.
// Throughput: one command at a time; the next is taken once the chain is back at rest.
// Reset (arst_n low, asynchronous) empties the list and drops any pending result word;
// stored entries keep no reset value.
`timescale 1ns / 1ps

module positional_array_engine
	import pae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [2:0]        func,
	input  logic [CNT_W-1:0]  position,
	input  logic signed [DATA_W-1:0] value,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [1:0]        status,
	output logic              found,
	output logic [CNT_W-1:0]  count,
	output logic signed [DATA_W-1:0] element,
	output logic              last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SORT = 3'd1;
	localparam logic [2:0] ST_FIND = 3'd2;
	localparam logic [2:0] ST_DUMP = 3'd3;
	localparam logic [2:0] ST_ROT  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(DEPTH - 1);

	logic [2:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rot_q;
	logic             phase_q;
	logic             desc_q;
	logic             hit_q;
	word_t            value_q;

	logic             rsp_valid_q;
	logic [1:0]       status_q;
	logic             found_q;
	logic [CNT_W-1:0] count_q;
	word_t            element_q;
	logic             last_q;

	logic             cmd_acc;
	logic             rsp_free;
	logic             ins_ok;
	logic             del_ok;
	logic             dump_last;
	cell_ctl_t        ctl;
	word_t            cell_data [DEPTH];

	assign cmd_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign ins_ok    = (position <= fill_q) && (fill_q < DEPTH_C);
	assign del_ok    = position < fill_q;
	assign dump_last = (rot_q + CNT_W'(1)) == fill_q;

	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.pos   = position;
		ctl.value = value;
		ctl.count = fill_q;
		ctl.phase = phase_q;
		ctl.desc  = desc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && func == FN_INSERT && ins_ok)
					ctl.op = CELL_INSERT;
				else if (cmd_acc && func == FN_DELETE && del_ok)
					ctl.op = CELL_DELETE;
			end
			ST_SORT: ctl.op = CELL_SORT;
			ST_FIND, ST_ROT: ctl.op = CELL_ROTATE;
			ST_DUMP: ctl.op = rsp_free ? CELL_ROTATE : CELL_HOLD;
			ST_DONE: ctl.op = CELL_HOLD;
			default: ctl.op = CELL_HOLD;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			pae_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.idx        (IDX_W'(gi)),
				.left_data  (cell_data[(gi + DEPTH - 1) % DEPTH]),
				.right_data (cell_data[(gi + 1) % DEPTH]),
				.data       (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rot_q       <= '0;
			phase_q     <= 1'b0;
			desc_q      <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						rot_q   <= '0;
						phase_q <= 1'b0;
						hit_q   <= 1'b0;
						value_q <= value;
						desc_q  <= (func == FN_DESC);
						// single-word commands post their result straight away
						rsp_valid_q <= 1'b1;
						status_q    <= RS_DONE;
						found_q     <= 1'b0;
						count_q     <= fill_q;
						element_q   <= '0;
						last_q      <= 1'b1;
						case (func)
							FN_CLEAR: begin
								fill_q  <= '0;
								count_q <= '0;
							end
							FN_INSERT: begin
								if (ins_ok) begin
									fill_q  <= fill_q + CNT_W'(1);
									count_q <= fill_q + CNT_W'(1);
								end else begin
									status_q <= RS_REJECT;
								end
							end
							FN_DELETE: begin
								if (del_ok) begin
									fill_q  <= fill_q - CNT_W'(1);
									count_q <= fill_q - CNT_W'(1);
								end else begin
									status_q <= RS_REJECT;
								end
							end
							FN_ASC, FN_DESC: begin
								rsp_valid_q <= 1'b0;
								state_q     <= ST_SORT;
							end
							FN_FIND: begin
								rsp_valid_q <= 1'b0;
								state_q     <= ST_FIND;
							end
							FN_DUMP: begin
								if (fill_q == '0) begin
									status_q <= RS_EMPTY;
								end else begin
									rsp_valid_q <= 1'b0;
									state_q     <= ST_DUMP;
								end
							end
							default: status_q <= RS_REJECT;
						endcase
					end
				end
				ST_SORT: begin
					phase_q <= !phase_q;
					rot_q   <= rot_q + CNT_W'(1);
					if (rot_q == LAST_C)
						state_q <= ST_DONE;
				end
				ST_FIND: begin
					if (rot_q < fill_q && cell_data[0] == value_q)
						hit_q <= 1'b1;
					rot_q <= rot_q + CNT_W'(1);
					if (rot_q == LAST_C)
						state_q <= ST_DONE;
				end
				ST_DUMP: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						status_q    <= RS_DONE;
						found_q     <= 1'b0;
						count_q     <= fill_q;
						element_q   <= cell_data[0];
						last_q      <= dump_last;
						rot_q       <= rot_q + CNT_W'(1);
						if (dump_last)
							state_q <= (rot_q == LAST_C) ? ST_IDLE : ST_ROT;
					end
				end
				ST_ROT: begin
					// finish the lap so every entry is back in its own cell
					rot_q <= rot_q + CNT_W'(1);
					if (rot_q == LAST_C)
						state_q <= ST_IDLE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						status_q    <= RS_DONE;
						found_q     <= hit_q;
						count_q     <= fill_q;
						element_q   <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign count     = count_q;
	assign element   = element_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond depth");

	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |=> fill_q == $past(fill_q))
		else $error("fill count changed while a command was running");

	a_sort_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT && !rsp_valid_q) |=> !rsp_valid_q)
		else $error("result word posted during sort");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && func == FN_INSERT && ins_ok) |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("accepted insert did not grow the list");

endmodule
